FILE: hdl/fmtr_pkg.sv
// ----------------------------------------------------------------------------
// fmtr_pkg
// Shared constants, sequencer states and divider handshake types for the
// frame rate meter and limiter.
// ----------------------------------------------------------------------------
package fmtr_pkg;

    localparam int WINDOW_LAST = 64;
    localparam int RING_DEPTH  = WINDOW_LAST + 1;
    localparam int IDX_W       = $clog2(RING_DEPTH);

    localparam int TS_W        = 32;
    localparam int FPS_W       = 16;
    localparam int SLEEP_W     = 10;
    localparam int LAST_W      = 11;
    localparam int LIMIT_W     = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;

    localparam int MS_PER_SEC  = 1000;
    localparam int SLEEP_CAP   = 300;
    localparam int FPS_IDLE    = 999;
    localparam int FPS_MAX     = 65535;

    localparam int NUM_W       = $clog2(WINDOW_LAST * MS_PER_SEC + 1);
    localparam int BASE_NUM_W  = $clog2(MS_PER_SEC + 1);
    localparam int DIV_W       = (NUM_W > BASE_NUM_W) ? NUM_W : BASE_NUM_W;
    localparam int SUM_W       = LAST_W + 1;

    localparam logic [CFG_IDX_W-1:0] REG_FG_MAX = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BG_MAX = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd2;

    localparam logic MODE_ABSOLUTE  = 1'b0;
    localparam logic MODE_CALCULATE = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_PREV,
        ST_RD_FIRST,
        ST_ELAPSED,
        ST_FPS,
        ST_FPS_WAIT,
        ST_BASE,
        ST_BASE_WAIT,
        ST_SLEEP,
        ST_OUT
    } fmtr_state_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [TS_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

FILE: hdl/frame_rate_meter_limiter.sv
// ----------------------------------------------------------------------------
// frame_rate_meter_limiter
// Frame rate meter over a ring of frame timestamps, with a foreground and
// background frame limiter that gives the sleep before the next frame.
// ----------------------------------------------------------------------------
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------------
//   in      | input     | in_valid / in_stall  | timestamp_ms, game_ready,
//           |           |                      | macro_running, foreground
//   out     | output    | out_valid / out_stall| frames_per_second,
//           |           |                      | frame_time_ms, sleep_ms,
//           |           |                      | current_limit, in_macro
//   cfg     | input     | cfg_write            | cfg_index, cfg_data
//
// One transfer reads the ring in ST_RD_PREV, ST_RD_FIRST and ST_ELAPSED, then
// the serial divider (one quotient bit per cycle) runs for the frame rate if the
// elapsed time is not zero, and for the base sleep if limit_go is set.
// in_stall is high while an item is in work; a finished result waits in the
// output register, so the next item is taken while out_stall holds it.
// Reset clears the write index and the limiter state; the ring has no reset.
// ----------------------------------------------------------------------------
module frame_rate_meter_limiter (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [fmtr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fmtr_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [fmtr_pkg::TS_W-1:0]         timestamp_ms,
    input  logic                              game_ready,
    input  logic                              macro_running,
    input  logic                              foreground,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [fmtr_pkg::FPS_W-1:0]        frames_per_second,
    output logic [fmtr_pkg::TS_W-1:0]         frame_time_ms,
    output logic [fmtr_pkg::SLEEP_W-1:0]      sleep_ms,
    output logic [fmtr_pkg::LIMIT_W-1:0]      current_limit,
    output logic                              in_macro
);
    import fmtr_pkg::*;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [TS_W-1:0]    ram_wdata;
    logic [IDX_W-1:0]   ram_raddr;
    logic [TS_W-1:0]    ram_rdata;
    div_req_t           div_req;
    div_rsp_t           div_rsp;

    fmtr_ram #(
        .WIDTH (TS_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    fmtr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    fmtr_ctrl u_ctrl (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .timestamp_ms      (timestamp_ms),
        .game_ready        (game_ready),
        .macro_running     (macro_running),
        .foreground        (foreground),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .frames_per_second (frames_per_second),
        .frame_time_ms     (frame_time_ms),
        .sleep_ms          (sleep_ms),
        .current_limit     (current_limit),
        .in_macro          (in_macro),
        .ram_we            (ram_we),
        .ram_waddr         (ram_waddr),
        .ram_wdata         (ram_wdata),
        .ram_raddr         (ram_raddr),
        .ram_rdata         (ram_rdata),
        .div_req           (div_req),
        .div_rsp           (div_rsp)
    );

    a_stall_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken while an item is in work");

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    a_macro_no_sleep: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && in_macro) |-> (sleep_ms == '0))
        else $error("sleep given under a macro");

    a_zero_limit_no_sleep: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (current_limit == '0)) |-> (sleep_ms == '0))
        else $error("sleep given with no limit");

endmodule

FILE: hdl/fmtr_ram.sv
// ----------------------------------------------------------------------------
// fmtr_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module fmtr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/fmtr_div.sv
// ----------------------------------------------------------------------------
// fmtr_div
// Shared restoring divider, one quotient bit per cycle, used for both the
// frame rate and the limiter base sleep.
// ----------------------------------------------------------------------------
module fmtr_div (
    input  logic              clk,
    input  logic              rst_n,
    input  fmtr_pkg::div_req_t req,
    output fmtr_pkg::div_rsp_t rsp
);
    import fmtr_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [TS_W-1:0]  rem_reg,  rem_next;
    logic [DIV_W-1:0] quo_reg,  quo_next;
    logic [TS_W-1:0]  dvs_reg,  dvs_next;
    logic [CNT_W-1:0] cnt_reg,  cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [TS_W:0]    trial;
    logic [TS_W:0]    diff;
    logic             fits;

    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start && !busy_reg)
        begin
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
            cnt_next  = CNT_W'(DIV_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[TS_W-1:0] : trial[TS_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

FILE: hdl/fmtr_ctrl.sv
// ----------------------------------------------------------------------------
// fmtr_ctrl
// Sequencer and datapath: ring addressing, frame time and elapsed time,
// limiter state, configuration registers and the output register.
// ----------------------------------------------------------------------------
module fmtr_ctrl (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [fmtr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fmtr_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [fmtr_pkg::TS_W-1:0]         timestamp_ms,
    input  logic                              game_ready,
    input  logic                              macro_running,
    input  logic                              foreground,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [fmtr_pkg::FPS_W-1:0]        frames_per_second,
    output logic [fmtr_pkg::TS_W-1:0]         frame_time_ms,
    output logic [fmtr_pkg::SLEEP_W-1:0]      sleep_ms,
    output logic [fmtr_pkg::LIMIT_W-1:0]      current_limit,
    output logic                              in_macro,
    output logic                              ram_we,
    output logic [fmtr_pkg::IDX_W-1:0]        ram_waddr,
    output logic [fmtr_pkg::TS_W-1:0]         ram_wdata,
    output logic [fmtr_pkg::IDX_W-1:0]        ram_raddr,
    input  logic [fmtr_pkg::TS_W-1:0]         ram_rdata,
    output fmtr_pkg::div_req_t                div_req,
    input  fmtr_pkg::div_rsp_t                div_rsp
);
    import fmtr_pkg::*;

    localparam int CMP_W = (DIV_W > FPS_W) ? DIV_W : FPS_W;

    fmtr_state_t         state_reg, state_next;

    logic [TS_W-1:0]     now_reg;
    logic                ready_reg;
    logic                macro_reg;
    logic                fg_reg;

    logic [IDX_W-1:0]    widx_reg;
    logic                filled_reg;
    logic [TS_W-1:0]     ft_reg;
    logic [TS_W-1:0]     elapsed_reg;
    logic [NUM_W-1:0]    num_reg;
    logic [FPS_W-1:0]    fps_reg;
    logic [SLEEP_W-1:0]  base_reg;
    logic [SLEEP_W-1:0]  sleep_reg;
    logic [LAST_W-1:0]   last_sleep_reg;
    logic [LIMIT_W-1:0]  held_limit_reg;
    logic                macro_flag_reg;

    logic [LIMIT_W-1:0]  fg_max_reg;
    logic [LIMIT_W-1:0]  bg_max_reg;
    logic                mode_reg;

    logic                out_valid_reg;
    logic [FPS_W-1:0]    out_fps_reg;
    logic [TS_W-1:0]     out_ft_reg;
    logic [SLEEP_W-1:0]  out_sleep_reg;
    logic [LIMIT_W-1:0]  out_limit_reg;
    logic                out_macro_reg;

    logic [IDX_W-1:0]    prev_idx;
    logic [IDX_W-1:0]    first_idx;
    logic [IDX_W-1:0]    frames;
    logic [LIMIT_W-1:0]  limit;
    logic                limit_go;
    logic                out_free;
    logic [SUM_W-1:0]    sleep_sum;
    logic [SUM_W-1:0]    sleep_diff;
    logic [SLEEP_W-1:0]  sleep_calc;

    assign prev_idx  = (widx_reg == '0) ? IDX_W'(WINDOW_LAST) : widx_reg - IDX_W'(1);
    assign first_idx = !filled_reg ? '0 :
                       (widx_reg == IDX_W'(WINDOW_LAST)) ? '0 : widx_reg + IDX_W'(1);
    assign frames    = filled_reg ? IDX_W'(WINDOW_LAST) : widx_reg;
    assign limit     = fg_reg ? fg_max_reg : bg_max_reg;
    assign limit_go  = ready_reg && !macro_reg && (limit != '0);
    assign out_free  = !out_valid_reg || !out_stall;

    assign sleep_sum  = SUM_W'(base_reg) + SUM_W'(last_sleep_reg);
    assign sleep_diff = sleep_sum - ft_reg[SUM_W-1:0];
    always_comb
    begin
        if (mode_reg == MODE_ABSOLUTE)
        begin
            sleep_calc = base_reg;
        end
        else if (ft_reg >= TS_W'(sleep_sum))
        begin
            sleep_calc = '0;
        end
        else if (sleep_diff > SUM_W'(SLEEP_CAP))
        begin
            sleep_calc = SLEEP_W'(SLEEP_CAP);
        end
        else
        begin
            sleep_calc = sleep_diff[SLEEP_W-1:0];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (in_valid) state_next = ST_RD_PREV;
            ST_RD_PREV:   state_next = ST_RD_FIRST;
            ST_RD_FIRST:  state_next = ST_ELAPSED;
            ST_ELAPSED:   state_next = ST_FPS;
            ST_FPS:       state_next = (elapsed_reg == '0) ? ST_BASE : ST_FPS_WAIT;
            ST_FPS_WAIT:  if (div_rsp.done) state_next = ST_BASE;
            ST_BASE:      state_next = limit_go ? ST_BASE_WAIT : ST_OUT;
            ST_BASE_WAIT: if (div_rsp.done) state_next = ST_SLEEP;
            ST_SLEEP:     state_next = ST_OUT;
            ST_OUT:       if (out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        in_stall         = 1'b1;
        ram_we           = 1'b0;
        ram_raddr        = first_idx;
        div_req.start    = 1'b0;
        div_req.dividend = DIV_W'(num_reg);
        div_req.divisor  = elapsed_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            ST_RD_PREV:
            begin
                ram_raddr = prev_idx;
            end
            ST_ELAPSED:
            begin
                ram_we = 1'b1;
            end
            ST_FPS:
            begin
                div_req.start = (elapsed_reg != '0);
            end
            ST_BASE:
            begin
                div_req.start    = limit_go;
                div_req.dividend = DIV_W'(MS_PER_SEC);
                div_req.divisor  = TS_W'(limit);
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    assign ram_waddr = widx_reg;
    assign ram_wdata = now_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            widx_reg       <= '0;
            filled_reg     <= 1'b0;
            last_sleep_reg <= '0;
            held_limit_reg <= '0;
            macro_flag_reg <= 1'b0;
            fg_max_reg     <= LIMIT_W'(50);
            bg_max_reg     <= LIMIT_W'(30);
            mode_reg       <= MODE_CALCULATE;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (state_reg == ST_ELAPSED)
            begin
                if (widx_reg == IDX_W'(WINDOW_LAST))
                begin
                    widx_reg   <= '0;
                    filled_reg <= 1'b1;
                end
                else
                begin
                    widx_reg <= widx_reg + IDX_W'(1);
                end
            end
            else if (cfg_write && (cfg_index == REG_MODE))
            begin
                widx_reg   <= '0;
                filled_reg <= 1'b0;
            end

            if (cfg_write)
            begin
                case (cfg_index)
                    REG_FG_MAX: fg_max_reg <= cfg_data;
                    REG_BG_MAX: bg_max_reg <= cfg_data;
                    REG_MODE:   mode_reg   <= cfg_data[0];
                    default:    mode_reg   <= mode_reg;
                endcase
            end

            if ((state_reg == ST_BASE) && ready_reg)
            begin
                macro_flag_reg <= macro_reg;
                if (!macro_reg)
                begin
                    held_limit_reg <= limit;
                end
            end

            if (state_reg == ST_SLEEP)
            begin
                last_sleep_reg <= LAST_W'(sleep_calc);
            end

            if ((state_reg == ST_OUT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && in_valid)
        begin
            now_reg   <= timestamp_ms;
            ready_reg <= game_ready;
            macro_reg <= macro_running;
            fg_reg    <= foreground;
        end

        if (state_reg == ST_RD_FIRST)
        begin
            ft_reg <= ((widx_reg == '0) && !filled_reg) ? '0 : now_reg - ram_rdata;
        end

        if (state_reg == ST_ELAPSED)
        begin
            elapsed_reg <= (first_idx == widx_reg) ? '0 : now_reg - ram_rdata;
            num_reg     <= NUM_W'(frames) * NUM_W'(MS_PER_SEC);
            fps_reg     <= FPS_W'(FPS_IDLE);
        end

        if ((state_reg == ST_FPS_WAIT) && div_rsp.done)
        begin
            if (CMP_W'(div_rsp.quotient) > CMP_W'(FPS_MAX))
            begin
                fps_reg <= FPS_W'(FPS_MAX);
            end
            else
            begin
                fps_reg <= FPS_W'(div_rsp.quotient);
            end
        end

        if (state_reg == ST_BASE)
        begin
            sleep_reg <= '0;
        end

        if ((state_reg == ST_BASE_WAIT) && div_rsp.done)
        begin
            base_reg <= SLEEP_W'(div_rsp.quotient);
        end

        if (state_reg == ST_SLEEP)
        begin
            sleep_reg <= sleep_calc;
        end

        if ((state_reg == ST_OUT) && out_free)
        begin
            out_fps_reg   <= fps_reg;
            out_ft_reg    <= ft_reg;
            out_sleep_reg <= sleep_reg;
            out_limit_reg <= held_limit_reg;
            out_macro_reg <= macro_flag_reg;
        end
    end

    assign out_valid         = out_valid_reg;
    assign frames_per_second = out_fps_reg;
    assign frame_time_ms     = out_ft_reg;
    assign sleep_ms          = out_sleep_reg;
    assign current_limit     = out_limit_reg;
    assign in_macro          = out_macro_reg;

endmodule
